>>> design/clts_pkg.sv
package clts_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_NUMBER  = 4'd1,
        KIND_PLUS    = 4'd2,
        KIND_MINUS   = 4'd3,
        KIND_STAR    = 4'd4,
        KIND_SLASH   = 4'd5,
        KIND_EQUAL   = 4'd6,
        KIND_SEMI    = 4'd7,
        KIND_LPAREN  = 4'd8,
        KIND_RPAREN  = 4'd9,
        KIND_LBRACE  = 4'd10,
        KIND_RBRACE  = 4'd11,
        KIND_EOF     = 4'd12,
        KIND_INVALID = 4'd13
    } kind_t;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_NUMBER = 2'd1,
        RUN_WORD   = 2'd2
    } run_mode_t;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_VTAB       = 8'h0B;
    localparam logic [7:0] CH_FORMFEED   = 8'h0C;
    localparam logic [7:0] CH_RETURN     = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic [15:0] length;
        logic [7:0]  bad;
    } tok_t;

    // one or two tokens caused by a single input beat
    typedef struct packed {
        tok_t first;
        tok_t second;
        logic two;
    } tok_pair_t;

    function automatic logic is_single(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH
            || c == CH_EQUAL || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN
            || c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_EQUAL:  k = KIND_EQUAL;
            CH_SEMI:   k = KIND_SEMI;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_INVALID;
        endcase
        return k;
    endfunction

endpackage

>>> design/clts_core.sv
module clts_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 op,
    input  logic [7:0]           ch,
    output logic                 any,
    output clts_pkg::tok_pair_t  pair
);
    import clts_pkg::*;

    run_mode_t   mode_reg,   mode_next;
    logic [23:0] line_reg,   line_next;
    logic [15:0] col_reg,    col_next;
    logic [31:0] off_reg,    off_next;
    logic [23:0] rline_reg,  rline_next;
    logic [15:0] rcol_reg,   rcol_next;
    logic [31:0] roff_reg,   roff_next;
    logic [15:0] rlen_reg,   rlen_next;

    logic        c_digit, c_alpha, c_word, c_space, c_single;
    logic        extend, close_run, own_valid;
    logic [23:0] line_inc;
    logic [15:0] col_inc, rlen_inc;
    logic [31:0] off_inc;
    tok_t        run_tok, own_tok;

    always_comb
    begin
        c_digit  = ch inside {[8'h30:8'h39]};
        c_alpha  = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        c_word   = c_digit || c_alpha || ch == CH_UNDERSCORE;
        c_space  = ch inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FORMFEED, CH_RETURN};
        c_single = is_single(ch);

        line_inc = (line_reg != '1) ? line_reg + 24'd1 : line_reg;
        col_inc  = (col_reg != '1) ? col_reg + 16'd1 : col_reg;
        off_inc  = (off_reg != '1) ? off_reg + 32'd1 : off_reg;
        rlen_inc = (rlen_reg != '1) ? rlen_reg + 16'd1 : rlen_reg;

        extend    = !op && ((mode_reg == RUN_NUMBER && c_digit)
                         || (mode_reg == RUN_WORD && c_word));
        close_run = !extend && mode_reg != RUN_NONE;

        run_tok.kind   = (mode_reg == RUN_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        run_tok.line   = rline_reg;
        run_tok.column = rcol_reg;
        run_tok.offset = roff_reg;
        run_tok.length = rlen_reg;
        run_tok.bad    = 8'd0;

        own_tok.line   = line_reg;
        own_tok.column = col_reg;
        own_tok.offset = off_reg;
        own_tok.length = 16'd1;
        own_tok.bad    = 8'd0;
        own_tok.kind   = KIND_INVALID;
        own_valid      = 1'b0;
        if (op)
        begin
            own_tok.kind   = KIND_EOF;
            own_tok.length = 16'd0;
            own_valid      = 1'b1;
        end
        else if (c_single)
        begin
            own_tok.kind = single_kind(ch);
            own_valid    = 1'b1;
        end
        else if (!extend && !c_space && !c_word)
        begin
            own_tok.bad = ch;
            own_valid   = 1'b1;
        end

        any         = close_run || own_valid;
        pair.first  = close_run ? run_tok : own_tok;
        pair.second = own_tok;
        pair.two    = close_run && own_valid;

        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        rline_next = rline_reg;
        rcol_next  = rcol_reg;
        roff_next  = roff_reg;
        rlen_next  = rlen_reg;
        if (op)
        begin
            mode_next  = RUN_NONE;
            line_next  = 24'd1;
            col_next   = 16'd1;
            off_next   = 32'd0;
            rline_next = 24'd1;
            rcol_next  = 16'd1;
            roff_next  = 32'd0;
            rlen_next  = 16'd0;
        end
        else if (extend)
        begin
            rlen_next = rlen_inc;
            col_next  = col_inc;
            off_next  = off_inc;
        end
        else
        begin
            mode_next = RUN_NONE;
            off_next  = off_inc;
            if (ch == CH_NEWLINE)
            begin
                line_next = line_inc;
                col_next  = 16'd1;
            end
            else
            begin
                col_next = col_inc;
            end
            if (!c_single && c_word)
            begin
                mode_next  = c_digit ? RUN_NUMBER : RUN_WORD;
                rline_next = line_reg;
                rcol_next  = col_reg;
                roff_next  = off_reg;
                rlen_next  = 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= RUN_NONE;
            line_reg  <= 24'd1;
            col_reg   <= 16'd1;
            off_reg   <= 32'd0;
            rline_reg <= 24'd1;
            rcol_reg  <= 16'd1;
            roff_reg  <= 32'd0;
            rlen_reg  <= 16'd0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            rline_reg <= rline_next;
            rcol_reg  <= rcol_next;
            roff_reg  <= roff_next;
            rlen_reg  <= rlen_next;
        end
    end

    // an open run never has zero length and columns never drop to zero
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != RUN_NONE |-> rlen_reg != 16'd0)
        else $error("open run with zero length");

    a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg != 16'd0 && line_reg != 24'd0)
        else $error("position counter reached zero");

    // end of source always restores the start position
    a_eof_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && op |=> mode_reg == RUN_NONE && off_reg == 32'd0 && col_reg == 16'd1)
        else $error("position not cleared after end of source");

endmodule

>>> design/c_like_token_scanner.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// input    | in_valid / in_ready        | op, ch
// result   | out_valid / out_ready      | kind, tok_line, tok_column, tok_offset,
//          |                            | tok_length, bad_byte, tok_file, run_last
// config   | cfg_wr_en (no wait)        | cfg_wr_data -> file_id
//
// One input beat per cycle unless the queue is full; each beat gives zero, one or two
// result beats, delivered one per cycle while out_ready is high, a pair in turn.
// Input beat is registered, scanned combinationally and its tokens pushed as one entry
// into a QUEUE_DEPTH-entry result queue; tokens leave no earlier than the cycle after.
// The input stage stalls while the queue is full, including a cycle that drains it.
// Reset (rst_n, async) clears position to line 1, column 1, offset 0 and file_id to 0.
module c_like_token_scanner #(
    parameter int QUEUE_DEPTH = clts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [23:0] tok_line,
    output logic [15:0] tok_column,
    output logic [31:0] tok_offset,
    output logic [15:0] tok_length,
    output logic [7:0]  bad_byte,
    output logic [31:0] tok_file,
    output logic        run_last
);
    import clts_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]   file_reg;
    logic          stg_valid_reg;
    logic          stg_op_reg;
    logic [7:0]    stg_ch_reg;
    logic          stg_adv;
    logic          any;
    tok_pair_t     pair;
    tok_pair_t     q_reg [QUEUE_DEPTH];
    tok_pair_t     head;
    tok_t          cur;
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sub_reg;
    logic          push, pop_beat, pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_reg <= 32'd0;
        else if (cfg_wr_en)
            file_reg <= cfg_wr_data;
    end

    assign stg_adv  = stg_valid_reg && (cnt_reg != CW'(QUEUE_DEPTH));
    assign in_ready = !stg_valid_reg || stg_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_ready)
            stg_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_op_reg <= op;
            stg_ch_reg <= ch;
        end
    end

    clts_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (stg_adv),
        .op    (stg_op_reg),
        .ch    (stg_ch_reg),
        .any   (any),
        .pair  (pair)
    );

    always_comb
    begin
        head      = q_reg[rd_ptr_reg];
        cur       = sub_reg ? head.second : head.first;
        out_valid = cnt_reg != '0;
        run_last  = sub_reg || !head.two;
        pop_beat  = out_valid && out_ready;
        pop_entry = pop_beat && run_last;
        push      = stg_adv && any;
        cnt_next  = cnt_reg;
        if (push && !pop_entry)
            cnt_next = cnt_reg + CW'(1);
        else if (!push && pop_entry)
            cnt_next = cnt_reg - CW'(1);
    end

    assign kind       = cur.kind;
    assign tok_line   = cur.line;
    assign tok_column = cur.column;
    assign tok_offset = cur.offset;
    assign tok_length = cur.length;
    assign bad_byte   = cur.bad;
    assign tok_file   = file_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop_entry)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (pop_beat)
                sub_reg <= !run_last;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_sub_two: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> out_valid && head.two)
        else $error("second token selected from single-token entry");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EOF |-> run_last && tok_length == 16'd0)
        else $error("end-of-file token not last of its beat");

    a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
        pop_beat && !run_last |=> sub_reg && out_valid)
        else $error("second token of a pair lost");

endmodule

>>> test/tb_c_like_token_scanner.sv
module tb_c_like_token_scanner;

    import clts_pkg::*;

    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_END       = 1'b1;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   LONG_HOLD    = 300;
    localparam int   STALL_LIMIT  = 2000;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } src_beat_t;

    typedef struct {
        kind_t       kind;
        logic [23:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic [15:0] length;
        logic [7:0]  bad;
        logic [31:0] file;
        logic        last;
    } tok_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_BYTE;
    logic [7:0]  ch = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  kind;
    logic [23:0] tok_line;
    logic [15:0] tok_column;
    logic [31:0] tok_offset;
    logic [15:0] tok_length;
    logic [7:0]  bad_byte;
    logic [31:0] tok_file;
    logic        run_last;

    src_beat_t byte_pending[$];
    tok_exp_t  tok_expected[$];

    // scanner shadow state
    run_mode_t   word_mode;
    logic [23:0] pos_line;
    logic [15:0] pos_col;
    logic [31:0] pos_off;
    logic [23:0] word_line;
    logic [15:0] word_col;
    logic [31:0] word_off;
    logic [15:0] word_len;
    logic [31:0] file_shadow;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_armed = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;

    int mismatches = 0;
    int items_added = 0;
    int items_taken = 0;
    int toks_seen = 0;
    int eof_seen = 0;
    int invalid_seen = 0;
    int settings_used = 0;

    c_like_token_scanner u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .tok_line   (tok_line),
        .tok_column (tok_column),
        .tok_offset (tok_offset),
        .tok_length (tok_length),
        .bad_byte   (bad_byte),
        .tok_file   (tok_file),
        .run_last   (run_last)
    );

    always #2 clk = ~clk;

    task automatic clear_scan_pos();
        word_mode = RUN_NONE;
        pos_line  = 24'd1;
        pos_col   = 16'd1;
        pos_off   = 32'd0;
        word_line = 24'd1;
        word_col  = 16'd1;
        word_off  = 32'd0;
        word_len  = 16'd0;
    endtask

    task automatic step_col();
        if (pos_col != '1)
            pos_col = pos_col + 1'b1;
        if (pos_off != '1)
            pos_off = pos_off + 1'b1;
    endtask

    function automatic tok_exp_t make_tok(kind_t k, logic [23:0] ln, logic [15:0] col,
                                          logic [31:0] off, logic [15:0] len,
                                          logic [7:0] bad);
        tok_exp_t t;
        t.kind   = k;
        t.line   = ln;
        t.column = col;
        t.offset = off;
        t.length = len;
        t.bad    = bad;
        t.file   = file_shadow;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic kind_t punct_kind(logic [7:0] b);
        case (b)
            CH_PLUS:   return KIND_PLUS;
            CH_MINUS:  return KIND_MINUS;
            CH_STAR:   return KIND_STAR;
            CH_SLASH:  return KIND_SLASH;
            CH_EQUAL:  return KIND_EQUAL;
            CH_SEMI:   return KIND_SEMI;
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            default:   return KIND_INVALID;
        endcase
    endfunction

    // works out the tokens caused by one accepted beat
    task automatic scan_beat(input logic is_end, input logic [7:0] b);
        tok_exp_t t[2];
        int       n;
        kind_t    pk;
        logic     digit_c;
        logic     alpha_c;
        logic     word_c;
        logic     space_c;
        n       = 0;
        digit_c = b >= 8'h30 && b <= 8'h39;
        alpha_c = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
        word_c  = alpha_c || digit_c || b == CH_UNDERSCORE;
        space_c = b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE || b == CH_VTAB
               || b == CH_FORMFEED || b == CH_RETURN;
        pk      = punct_kind(b);
        if (!is_end && ((word_mode == RUN_NUMBER && digit_c)
                        || (word_mode == RUN_WORD && word_c))) begin
            if (word_len != '1)
                word_len = word_len + 1'b1;
            step_col();
        end else begin
            if (word_mode != RUN_NONE) begin
                t[n] = make_tok(word_mode == RUN_NUMBER ? KIND_NUMBER : KIND_IDENT,
                                word_line, word_col, word_off, word_len, 8'd0);
                n++;
                word_mode = RUN_NONE;
            end
            if (is_end) begin
                t[n] = make_tok(KIND_EOF, pos_line, pos_col, pos_off, 16'd0, 8'd0);
                n++;
                clear_scan_pos();
            end else if (space_c) begin
                if (b == CH_NEWLINE) begin
                    if (pos_line != '1)
                        pos_line = pos_line + 1'b1;
                    pos_col = 16'd1;
                    if (pos_off != '1)
                        pos_off = pos_off + 1'b1;
                end else begin
                    step_col();
                end
            end else if (pk != KIND_INVALID) begin
                t[n] = make_tok(pk, pos_line, pos_col, pos_off, 16'd1, 8'd0);
                n++;
                step_col();
            end else if (digit_c || alpha_c || b == CH_UNDERSCORE) begin
                word_mode = digit_c ? RUN_NUMBER : RUN_WORD;
                word_line = pos_line;
                word_col  = pos_col;
                word_off  = pos_off;
                word_len  = 16'd1;
                step_col();
            end else begin
                t[n] = make_tok(KIND_INVALID, pos_line, pos_col, pos_off, 16'd1, b);
                n++;
                step_col();
            end
        end
        if (n > 0)
            t[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            tok_expected.push_back(t[i]);
    endtask

    // driver
    always @(posedge clk) begin : driver
        src_beat_t nxt;
        logic      take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && in_ready;
            if (take) begin
                scan_beat(op, ch);
                items_taken++;
            end
            if (!in_valid || take) begin
                if (byte_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_pending.pop_front();
                    in_valid <= 1'b1;
                    op       <= nxt.op;
                    ch       <= nxt.ch;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin : monitor
        tok_exp_t e;
        logic     rdy;
        logic     bad;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                toks_seen++;
                if (kind == KIND_EOF)
                    eof_seen++;
                if (kind == KIND_INVALID)
                    invalid_seen++;
                if (tok_expected.size() == 0) begin
                    $error("token beat with nothing expected: kind %0d offset %0h",
                           kind, tok_offset);
                    mismatches++;
                end else begin
                    e   = tok_expected.pop_front();
                    bad = 1'b0;
                    if (kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, kind);
                        bad = 1'b1;
                    end
                    if (tok_line !== e.line) begin
                        $error("tok_line: expected %0h, got %0h", e.line, tok_line);
                        bad = 1'b1;
                    end
                    if (tok_column !== e.column) begin
                        $error("tok_column: expected %0h, got %0h", e.column, tok_column);
                        bad = 1'b1;
                    end
                    if (tok_offset !== e.offset) begin
                        $error("tok_offset: expected %0h, got %0h", e.offset, tok_offset);
                        bad = 1'b1;
                    end
                    if (tok_length !== e.length) begin
                        $error("tok_length: expected %0h, got %0h", e.length, tok_length);
                        bad = 1'b1;
                    end
                    if (bad_byte !== e.bad) begin
                        $error("bad_byte: expected %0h, got %0h", e.bad, bad_byte);
                        bad = 1'b1;
                    end
                    if (tok_file !== e.file) begin
                        $error("tok_file: expected %0h, got %0h", e.file, tok_file);
                        bad = 1'b1;
                    end
                    if (run_last !== e.last) begin
                        $error("run_last: expected %0b, got %0b", e.last, run_last);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end
            rdy = 1'b0;
            if (hold_armed && !hold_taken) begin
                hold_left  <= LONG_HOLD;
                hold_taken <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else begin
                rdy = $urandom_range(99) >= recv_stall_pct;
            end
            out_ready <= rdy;
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_pending.push_back('{op: OP_BYTE, ch: b});
        items_added++;
    endtask

    task automatic push_end();
        byte_pending.push_back('{op: OP_END, ch: 8'($urandom_range(255))});
        items_added++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(62);
        if (r < 26)
            return 8'h61 + 8'(r);
        else if (r < 52)
            return 8'h41 + 8'(r - 26);
        else if (r < 62)
            return 8'h30 + 8'(r - 52);
        else
            return CH_UNDERSCORE;
    endfunction

    // random source text: mostly well-formed fragments, some noise
    task automatic push_source(input int count);
        int target;
        int r;
        int len;
        target = items_added + count;
        while (items_added < target) begin
            r = $urandom_range(99);
            if (r < 25) begin
                len = $urandom_range(8, 1);
                push_byte($urandom_range(7) == 0 ? CH_UNDERSCORE
                                                 : 8'h61 + 8'($urandom_range(25)));
                for (int i = 1; i < len; i++)
                    push_byte(pick_word_char());
            end else if (r < 40) begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    push_byte(8'h30 + 8'($urandom_range(9)));
            end else if (r < 60) begin
                case ($urandom_range(9))
                    0: push_byte(CH_PLUS);
                    1: push_byte(CH_MINUS);
                    2: push_byte(CH_STAR);
                    3: push_byte(CH_SLASH);
                    4: push_byte(CH_EQUAL);
                    5: push_byte(CH_SEMI);
                    6: push_byte(CH_LPAREN);
                    7: push_byte(CH_RPAREN);
                    8: push_byte(CH_LBRACE);
                    default: push_byte(CH_RBRACE);
                endcase
            end else if (r < 75) begin
                case ($urandom_range(5))
                    0: push_byte(CH_SPACE);
                    1: push_byte(CH_TAB);
                    2: push_byte(CH_NEWLINE);
                    3: push_byte(CH_VTAB);
                    4: push_byte(CH_FORMFEED);
                    default: push_byte(CH_RETURN);
                endcase
            end else if (r < 82) begin
                push_byte(8'($urandom_range(255, 128)));
            end else if (r < 96) begin
                push_byte(8'($urandom_range(255)));
            end else begin
                push_end();
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (byte_pending.size() != 0 || in_valid || tok_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic start_phase(input logic [31:0] fid, input int send_pct, input int recv_pct);
        wait_idle();
        @(posedge clk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= fid;
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        file_shadow = fid;
        settings_used++;
        @(negedge clk);
    endtask

    initial begin : stimulus
        file_shadow = '0;
        clear_scan_pos();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operator, whitespace, invalid extremes, run closing, end of source
        start_phase(32'hFFFF_FFFF, 0, 0);
        push_text("x_9+12-*/=;(){}");
        push_byte(CH_SPACE);
        push_byte(CH_TAB);
        push_byte(CH_VTAB);
        push_byte(CH_FORMFEED);
        push_byte(CH_RETURN);
        push_byte(CH_NEWLINE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("7a");
        push_end();
        push_end();

        start_phase($urandom, 71, 0);
        push_source(500);

        // receiver holds off while the sender keeps offering
        start_phase($urandom, 0, 71);
        hold_armed = 1'b1;
        push_source(500);

        start_phase(32'h8000_0001, 37, 37);
        push_source(500);

        // sender pauses mid-phase until every token has come
        start_phase($urandom, 0, 0);
        push_source(200);
        wait_idle();
        push_source(250);

        wait_idle();
        $display("covered %0d input beats, %0d tokens (%0d end of source, %0d invalid)",
                 items_taken, toks_seen, eof_seen, invalid_seen);
        $display("%0d file number settings across idle, stalled and long-hold phases",
                 settings_used);
        if (mismatches == 0 && tok_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
